[sv/lctc_pkg.sv]
// ----------------------------------------------------------------------------
// lctc_pkg
// Shared types and codes for the line crossing track counter.
// ----------------------------------------------------------------------------
package lctc_pkg;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_A    = 2'd1,
        SIDE_B    = 2'd2
    } side_t;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_A2B   = 2'd1;
    localparam logic [1:0] EV_B2A   = 2'd2;
    localparam logic [1:0] EV_OTHER = 2'd3;

    localparam logic [2:0] CFG_START_X = 3'd0;
    localparam logic [2:0] CFG_START_Y = 3'd1;
    localparam logic [2:0] CFG_END_X   = 3'd2;
    localparam logic [2:0] CFG_END_Y   = 3'd3;
    localparam logic [2:0] CFG_ENABLE  = 3'd4;

    localparam logic [7:0] ACT_SKIP_LO = 8'd4;
    localparam logic [7:0] ACT_SKIP_HI = 8'd8;

    localparam int CNT_W   = 32;
    localparam int ID_W    = 16;
    localparam int COORD_W = 12;

    // scan result from the track table
    typedef struct packed {
        logic  done;
        logic  hit;
        logic  free_ok;
        side_t hit_side;
    } tbl_stat_t;

    // write / drop request to the track table
    typedef struct packed {
        logic              set_en;
        logic              clr_en;
        logic [ID_W-1:0]   track;
        side_t             side;
    } tbl_wr_t;

    // counter update request
    typedef struct packed {
        logic en;
        logic fwd;
        logic a2b;
        logic b2a;
    } cnt_upd_t;

endpackage

[sv/lctc_table.sv]
// ----------------------------------------------------------------------------
// lctc_table
// Track table: one slot compared per cycle against the current id, first hit
// and lowest free slot recorded. Slot id/side live in a registered-read RAM.
// ----------------------------------------------------------------------------
module lctc_table #(
    parameter int TRACK_SLOTS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [15:0]           id,
    output lctc_pkg::tbl_stat_t   stat,
    output logic [IDX_W-1:0]      hit_idx,
    output logic [IDX_W-1:0]      free_idx,
    input  lctc_pkg::tbl_wr_t     wr,
    input  logic [IDX_W-1:0]      set_idx,
    input  logic [IDX_W-1:0]      clr_idx
);
    import lctc_pkg::*;

    localparam int SC_W = $clog2(TRACK_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_SLOTS - 1);

    logic [ID_W-1:0] mem_track [TRACK_SLOTS];
    side_t           mem_side  [TRACK_SLOTS];
    logic [TRACK_SLOTS-1:0] valid_reg;

    logic             busy_reg;
    logic [SC_W-1:0]  addr_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [ID_W-1:0]  rd_track_reg;
    side_t            rd_side_reg;

    logic             hit_reg, free_reg, done_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    side_t            hit_side_reg;

    logic issue, is_hit, is_free;

    assign issue   = busy_reg && (addr_reg < SC_W'(TRACK_SLOTS));
    assign is_hit  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_track_reg == id);
    assign is_free = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    // slot RAM
    always_ff @(posedge aclk) begin
        if (wr.set_en) begin
            mem_track[set_idx] <= wr.track;
            mem_side[set_idx]  <= wr.side;
        end
        if (issue) begin
            rd_track_reg <= mem_track[addr_reg[IDX_W-1:0]];
            rd_side_reg  <= mem_side[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            busy_reg    <= 1'b0;
            addr_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (wr.clr_en) valid_reg[clr_idx] <= 1'b0;
            if (wr.set_en) valid_reg[set_idx] <= 1'b1;

            if (start) begin
                busy_reg    <= 1'b1;
                addr_reg    <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
            end else begin
                cmp_vld_reg <= issue;
                if (issue) begin
                    cmp_idx_reg <= addr_reg[IDX_W-1:0];
                    addr_reg    <= addr_reg + SC_W'(1);
                end
                if (is_hit && !hit_reg) begin
                    hit_reg <= 1'b1;
                end
                if (is_free && !free_reg) begin
                    free_reg <= 1'b1;
                end
                if (cmp_vld_reg && cmp_idx_reg == LAST_IDX) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload of the first hit / first free slot
    always_ff @(posedge aclk) begin
        if (is_hit && !hit_reg) begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_side_reg <= rd_side_reg;
        end
        if (is_free && !free_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    assign stat.done     = done_reg;
    assign stat.hit      = hit_reg;
    assign stat.free_ok  = free_reg;
    assign stat.hit_side = hit_side_reg;
    assign hit_idx       = hit_idx_reg;
    assign free_idx      = free_idx_reg;

endmodule

[sv/lctc_counters.sv]
// ----------------------------------------------------------------------------
// lctc_counters
// Saturating crossing counters and the wrong-direction flag.
// ----------------------------------------------------------------------------
module lctc_counters (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lctc_pkg::cnt_upd_t   upd,
    output logic [31:0]          a2b,
    output logic [31:0]          b2a,
    output logic [31:0]          fwd,
    output logic [31:0]          rev,
    output logic                 wrong_dir
);
    import lctc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [CNT_W-1:0] a2b_reg, b2a_reg, fwd_reg, rev_reg;
    logic [CNT_W-1:0] a2b_next, b2a_next, fwd_next, rev_next;
    logic             flag_reg;

    always_comb begin
        a2b_next = a2b_reg;
        b2a_next = b2a_reg;
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        if (upd.a2b && a2b_reg != CNT_MAX) a2b_next = a2b_reg + CNT_W'(1);
        if (upd.b2a && b2a_reg != CNT_MAX) b2a_next = b2a_reg + CNT_W'(1);
        if (upd.fwd) begin
            if (fwd_reg != CNT_MAX) fwd_next = fwd_reg + CNT_W'(1);
        end else begin
            if (rev_reg != CNT_MAX) rev_next = rev_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a2b_reg  <= '0;
            b2a_reg  <= '0;
            fwd_reg  <= '0;
            rev_reg  <= '0;
            flag_reg <= 1'b0;
        end else if (upd.en) begin
            a2b_reg  <= a2b_next;
            b2a_reg  <= b2a_next;
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            flag_reg <= !(fwd_next > rev_next);
        end
    end

    assign a2b       = a2b_reg;
    assign b2a       = b2a_reg;
    assign fwd       = fwd_reg;
    assign rev       = rev_reg;
    assign wrong_dir = flag_reg;

endmodule

[sv/line_crossing_track_counter.sv]
// ----------------------------------------------------------------------------
// line_crossing_track_counter
// Counts tracked objects crossing a configured virtual line.
// ----------------------------------------------------------------------------
// Each input transaction is one track update, and each one produces exactly
// one output transaction.
// An update whose active count is 4 or 8 is skipped: it goes straight to the
// output state. Any other update scans the track table one slot per cycle
// through a single id comparator on the table RAM read port. That path runs
// through a start step, the RAM read, the compare of every slot and then a
// decision step before the output state. In both cases the next update can
// be accepted once the block is back in idle.
// s_tready is high only while no update is in flight. A finished result sits
// in the output register until m_tready takes it. If the next update finishes
// while that result is still waiting, the block holds in its output state
// for as long as m_tready stays low.
// Configuration writes are expected only while the block is idle.
module line_crossing_track_counter #(
    parameter int TRACK_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [11:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] track_id, [31:16] centroid_x, [47:32] centroid_y,
    // [55:48] active_frames, [63:56] inactive_frames
    input  logic [63:0]  s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] crossing_event, [33:2] total_a_to_b, [65:34] total_b_to_a,
    // [97:66] total_forward, [129:98] total_reverse, [130] wrong_direction,
    // [131] table_full, [135:132] zero
    output logic [135:0] m_tdata
);
    import lctc_pkg::*;

    localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;

    // configuration
    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic               en_reg;

    state_t state_reg;

    // latched update
    logic [15:0] id_reg, cx_reg, cy_reg;
    logic        missing_reg;
    logic        start_reg;

    logic [1:0]  event_reg;
    logic        full_reg;

    logic         m_tvalid_reg;
    logic [135:0] m_tdata_reg;

    tbl_stat_t        stat;
    tbl_wr_t          wr;
    logic [IDX_W-1:0] hit_idx, free_idx, set_idx, clr_idx;
    cnt_upd_t         upd;

    logic [31:0] a2b, b2a, fwd, rev;
    logic        wrong_dir;

    logic s_acc, skip;
    side_t new_side;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign skip     = (s_tdata[55:48] == ACT_SKIP_LO) || (s_tdata[55:48] == ACT_SKIP_HI);

    // side of the latched centroid relative to the line's first endpoint
    always_comb begin
        logic [COORD_W-1:0] dx, dy;
        logic [15:0]        rx, ry;
        dx = (x0_reg > x1_reg) ? (x0_reg - x1_reg) : (x1_reg - x0_reg);
        dy = (y0_reg > y1_reg) ? (y0_reg - y1_reg) : (y1_reg - y0_reg);
        rx = {x0_reg, 4'b0000};
        ry = {y0_reg, 4'b0000};
        new_side = SIDE_NONE;
        if (en_reg) begin
            if (dx < dy) begin
                if (cx_reg < rx)      new_side = SIDE_A;
                else if (cx_reg > rx) new_side = SIDE_B;
            end else if (dx > dy) begin
                if (cy_reg > ry)      new_side = SIDE_A;
                else if (cy_reg < ry) new_side = SIDE_B;
            end
        end
    end

    // decision at the end of the table scan
    always_comb begin
        wr.set_en = 1'b0;
        wr.clr_en = 1'b0;
        wr.track  = id_reg;
        wr.side   = new_side;
        set_idx   = free_idx;
        clr_idx   = hit_idx;
        upd.en    = 1'b0;
        upd.fwd   = (stat.hit_side < new_side);
        upd.a2b   = (stat.hit_side == SIDE_A) && (new_side == SIDE_B);
        upd.b2a   = (stat.hit_side == SIDE_B) && (new_side == SIDE_A);
        if (state_reg == S_SCAN && stat.done) begin
            if (missing_reg) begin
                wr.clr_en = stat.hit;
            end else if (stat.hit) begin
                if (new_side != stat.hit_side) begin
                    upd.en    = 1'b1;
                    wr.clr_en = 1'b1;
                end
            end else if (new_side != SIDE_NONE) begin
                wr.set_en = stat.free_ok;
            end
        end
    end

    lctc_table #(
        .TRACK_SLOTS (TRACK_SLOTS),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .id       (id_reg),
        .stat     (stat),
        .hit_idx  (hit_idx),
        .free_idx (free_idx),
        .wr       (wr),
        .set_idx  (set_idx),
        .clr_idx  (clr_idx)
    );

    lctc_counters u_counters (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (upd),
        .a2b       (a2b),
        .b2a       (b2a),
        .fwd       (fwd),
        .rev       (rev),
        .wrong_dir (wrong_dir)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg <= '0;
            y0_reg <= '0;
            x1_reg <= '0;
            y1_reg <= '0;
            en_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_X: x0_reg <= cfg_wdata;
                CFG_START_Y: y0_reg <= cfg_wdata;
                CFG_END_X:   x1_reg <= cfg_wdata;
                CFG_END_Y:   y1_reg <= cfg_wdata;
                CFG_ENABLE:  en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input latch, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            id_reg      <= s_tdata[15:0];
            cx_reg      <= s_tdata[31:16];
            cy_reg      <= s_tdata[47:32];
            missing_reg <= (s_tdata[63:56] != 8'd0);
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            event_reg    <= EV_NONE;
            full_reg     <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            // load a new result, or retire the one that was taken
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        event_reg <= EV_NONE;
                        full_reg  <= 1'b0;
                        if (skip) begin
                            state_reg <= S_OUT;
                        end else begin
                            start_reg <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (stat.done) begin
                        if (!missing_reg && stat.hit && new_side != stat.hit_side) begin
                            if (upd.a2b)      event_reg <= EV_A2B;
                            else if (upd.b2a) event_reg <= EV_B2A;
                            else              event_reg <= EV_OTHER;
                        end
                        if (!missing_reg && !stat.hit && new_side != SIDE_NONE
                            && !stat.free_ok) begin
                            full_reg <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // counters have settled by now
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {4'b0000, full_reg, wrong_dir, rev, fwd, b2a, a2b, event_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[sv/lctc_checker.sv]
// ----------------------------------------------------------------------------
// lctc_checker
// Port-level checks for the line crossing track counter, bound to the top.
// ----------------------------------------------------------------------------
module lctc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    import lctc_pkg::*;

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // one update in flight at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second update while busy");

    // a crossing event always shows a nonzero direction count
    a_evt_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != EV_NONE) |->
            (m_tdata[97:66] != 32'd0) || (m_tdata[129:98] != 32'd0))
        else $error("crossing event with zero direction counts");

    // flag matches counts on a crossing
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != EV_NONE) |->
            m_tdata[130] == (m_tdata[97:66] <= m_tdata[129:98]))
        else $error("wrong_direction inconsistent with counts");

    // table full only on a new track, never with an event
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[131] |-> m_tdata[1:0] == EV_NONE)
        else $error("table_full together with a crossing event");

endmodule

bind line_crossing_track_counter lctc_checker u_lctc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/line_crossing_track_counter_checker.sv]
// ----------------------------------------------------------------------------
// line_crossing_track_counter_checker
// Watches the line crossing counter's channels, predicts and compares.
// ----------------------------------------------------------------------------
// Follows config writes and every input transaction with its own track table
// and counters, queues one expected result per update and checks each result
// transaction field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module line_crossing_track_counter_checker #(
    parameter int TRACK_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [11:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    output int           mismatches,
    output int           awaiting,
    output int           results_seen,
    output int           crossings_seen,
    output int           full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lctc_pkg::*;

    // same layout as m_tdata[131:0], lowest field declared last
    typedef struct packed {
        logic        table_full;
        logic        wrong_dir;
        logic [31:0] rev_total;
        logic [31:0] fwd_total;
        logic [31:0] b2a_total;
        logic [31:0] a2b_total;
        logic [1:0]  crossing;
    } tally_t;

    logic [11:0] ln_x0, ln_y0, ln_x1, ln_y1;
    logic        ln_on;

    logic        slot_used [TRACK_SLOTS];
    logic [15:0] slot_id   [TRACK_SLOTS];
    side_t       slot_at   [TRACK_SLOTS];

    logic [31:0] tot_a2b, tot_b2a, tot_fwd, tot_rev;
    logic        wrong_dir;

    tally_t results_due[$];

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic side_t classify_side(logic [15:0] cx, logic [15:0] cy);
        logic [11:0] dx, dy;
        logic [15:0] rx, ry;
        dx = (ln_x0 > ln_x1) ? ln_x0 - ln_x1 : ln_x1 - ln_x0;
        dy = (ln_y0 > ln_y1) ? ln_y0 - ln_y1 : ln_y1 - ln_y0;
        rx = {ln_x0, 4'b0000};
        ry = {ln_y0, 4'b0000};
        if (!ln_on)
            return SIDE_NONE;
        if (dx < dy) begin
            if (cx < rx) return SIDE_A;
            if (cx > rx) return SIDE_B;
            return SIDE_NONE;
        end
        if (dx > dy) begin
            if (cy > ry) return SIDE_A;
            if (cy < ry) return SIDE_B;
            return SIDE_NONE;
        end
        return SIDE_NONE;
    endfunction

    // applies one track update to the shadow state, returns the result
    function automatic tally_t apply_update(logic [63:0] d);
        logic [15:0] id, cx, cy;
        logic [7:0]  act, inact;
        tally_t      r;
        int          hit, hole;
        side_t       was, now;
        id    = d[15:0];
        cx    = d[31:16];
        cy    = d[47:32];
        act   = d[55:48];
        inact = d[63:56];
        r     = '0;
        r.crossing = EV_NONE;
        if (act != ACT_SKIP_LO && act != ACT_SKIP_HI) begin
            hit = -1;
            for (int i = 0; i < TRACK_SLOTS; i++)
                if (hit < 0 && slot_used[i] && slot_id[i] == id)
                    hit = i;
            if (inact != 8'd0) begin
                if (hit >= 0)
                    slot_used[hit] = 1'b0;
            end else if (hit >= 0) begin
                was = slot_at[hit];
                now = classify_side(cx, cy);
                if (now != was) begin
                    if (was < now)
                        tot_fwd = bump(tot_fwd);
                    else
                        tot_rev = bump(tot_rev);
                    wrong_dir = !(tot_fwd > tot_rev);
                    if (was == SIDE_A && now == SIDE_B) begin
                        tot_a2b = bump(tot_a2b);
                        r.crossing = EV_A2B;
                    end else if (was == SIDE_B && now == SIDE_A) begin
                        tot_b2a = bump(tot_b2a);
                        r.crossing = EV_B2A;
                    end else begin
                        r.crossing = EV_OTHER;
                    end
                    slot_used[hit] = 1'b0;
                end
            end else begin
                now = classify_side(cx, cy);
                if (now != SIDE_NONE) begin
                    hole = -1;
                    for (int i = 0; i < TRACK_SLOTS; i++)
                        if (hole < 0 && !slot_used[i])
                            hole = i;
                    if (hole >= 0) begin
                        slot_used[hole] = 1'b1;
                        slot_id[hole]   = id;
                        slot_at[hole]   = now;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
            end
        end
        r.a2b_total = tot_a2b;
        r.b2a_total = tot_b2a;
        r.fwd_total = tot_fwd;
        r.rev_total = tot_rev;
        r.wrong_dir = wrong_dir;
        return r;
    endfunction

    // appends one expected result at the tail of the queue
    task automatic queue_expected(tally_t t);
        results_due.insert(results_due.size(), t);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $realtime, results_seen, what, got, want);
    endtask

    task automatic compare_result(tally_t got, tally_t want, logic [3:0] pad);
        if (got.crossing != want.crossing)
            report_mismatch("crossing_event", 32'(got.crossing), 32'(want.crossing));
        if (got.a2b_total != want.a2b_total)
            report_mismatch("total_a_to_b", got.a2b_total, want.a2b_total);
        if (got.b2a_total != want.b2a_total)
            report_mismatch("total_b_to_a", got.b2a_total, want.b2a_total);
        if (got.fwd_total != want.fwd_total)
            report_mismatch("total_forward", got.fwd_total, want.fwd_total);
        if (got.rev_total != want.rev_total)
            report_mismatch("total_reverse", got.rev_total, want.rev_total);
        if (got.wrong_dir != want.wrong_dir)
            report_mismatch("wrong_direction", 32'(got.wrong_dir), 32'(want.wrong_dir));
        if (got.table_full != want.table_full)
            report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
        if (pad != 4'd0)
            report_mismatch("pad bits", 32'(pad), 32'd0);
    endtask

    always @(posedge aclk) begin : monitor
        tally_t got, want;
        if (!aresetn) begin
            ln_x0 = '0;
            ln_y0 = '0;
            ln_x1 = '0;
            ln_y1 = '0;
            ln_on = 1'b0;
            for (int i = 0; i < TRACK_SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_id[i]   = '0;
                slot_at[i]   = SIDE_NONE;
            end
            tot_a2b   = '0;
            tot_b2a   = '0;
            tot_fwd   = '0;
            tot_rev   = '0;
            wrong_dir = 1'b0;
            results_due.delete();
            mismatches     = 0;
            results_seen   = 0;
            crossings_seen = 0;
            full_seen      = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_START_X: ln_x0 = cfg_wdata;
                    CFG_START_Y: ln_y0 = cfg_wdata;
                    CFG_END_X:   ln_x1 = cfg_wdata;
                    CFG_END_Y:   ln_y1 = cfg_wdata;
                    CFG_ENABLE:  ln_on = cfg_wdata[0];
                    default: ;
                endcase
            end
            // retire before queuing so a same-edge input lands behind
            if (m_tvalid && m_tready) begin
                got = m_tdata[131:0];
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    32'(got.crossing), 32'd0);
                end else begin
                    want = results_due.pop_front();
                    compare_result(got, want, m_tdata[135:132]);
                    if (want.crossing != EV_NONE)
                        crossings_seen++;
                    if (want.table_full)
                        full_seen++;
                end
            end
            if (s_tvalid && s_tready)
                queue_expected(apply_update(s_tdata));
        end
        awaiting <= results_due.size();
    end

endmodule

[dv/line_crossing_track_counter_tb.sv]
// ----------------------------------------------------------------------------
// line_crossing_track_counter_tb
// Stimulus and verdict for the line crossing track counter.
// ----------------------------------------------------------------------------
// Runs a directed sequence of track updates, then random track histories and
// noise under a series of line settings (vertical, horizontal, lines on the
// frame edges, equal extents, a single point, counting off). Both stream
// sides stall at random. The checker module does all prediction.
// ----------------------------------------------------------------------------
module line_crossing_track_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lctc_pkg::*;

    localparam int TRACK_SLOTS        = 16;
    localparam int MAX_WAIT           = 10;
    // an update scans the whole table, so let that much time pass when idle
    localparam int SETTLE_CYCLES      = TRACK_SLOTS + 8;
    // quiet cycles before giving up
    localparam int STALL_LIMIT        = 2000;
    localparam int RANDOM_PER_SETTING = 190;
    localparam int POOL_SIZE          = 24;
    // first register index past the defined ones (writes there are no-ops)
    localparam logic [2:0] CFG_SPARE  = CFG_ENABLE + 3'd1;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [11:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    // [15:0] track_id, [31:16] centroid_x, [47:32] centroid_y,
    // [55:48] active_frames, [63:56] inactive_frames
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // [1:0] crossing_event, [33:2] total_a_to_b, [65:34] total_b_to_a,
    // [97:66] total_forward, [129:98] total_reverse, [130] wrong_direction,
    // [131] table_full, [135:132] zero
    logic [135:0] m_tdata;

    int mismatches, awaiting, results_seen, crossings_seen, full_seen;

    // current line, kept here only to aim centroids near it
    logic [11:0] aim_x0, aim_y0;
    logic [15:0] id_pool [POOL_SIZE];
    bit          calm;          // both sides run without gaps while set
    int          updates_sent;
    int          settings_used;
    int          quiet_cycles;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    line_crossing_track_counter #(
        .TRACK_SLOTS (TRACK_SLOTS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    line_crossing_track_counter_checker #(
        .TRACK_SLOTS (TRACK_SLOTS)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .awaiting       (awaiting),
        .results_seen   (results_seen),
        .crossings_seen (crossings_seen),
        .full_seen      (full_seen)
    );

    // ------------------------------------------------------------------
    // Watchdog: any accepted transaction or config write resets the count
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, awaiting);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall before each result, then hold ready
    // until the transaction happens. Everything moves on falling edges.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Called on a falling edge, returns on a falling edge. With no gap the
    // valid just stays high and only the data changes.
    task automatic send_update(logic [15:0] id, logic [15:0] cx, logic [15:0] cy,
                               logic [7:0] act, logic [7:0] inact);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {inact, act, cy, cx, id};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        updates_sent++;
        // switch now and then between gappy traffic and full-rate stretches
        if (updates_sent % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    // Drain the block, then program a new line. The enable word carries
    // random upper bits, which must be ignored; an unused index is hit too.
    task automatic set_line(logic [11:0] x0, logic [11:0] y0, logic [11:0] x1,
                            logic [11:0] y1, logic on);
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(CFG_START_X, x0);
        write_reg(CFG_START_Y, y0);
        write_reg(CFG_END_X, x1);
        write_reg(CFG_END_Y, y1);
        write_reg(CFG_ENABLE, {11'($urandom), on});
        write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), 12'($urandom));
        cfg_we <= 1'b0;
        aim_x0 = x0;
        aim_y0 = y0;
        settings_used++;
        // a fresh random last member of the id pool for each setting
        id_pool[POOL_SIZE-1] = 16'($urandom);
    endtask

    // Coordinate close to the line reference (pixel * 16): below, above,
    // exactly on it, or anywhere.
    function automatic logic [15:0] near_line(logic [11:0] base);
        int c, pick;
        c    = int'(base) * 16;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            c = c - int'($urandom_range(1, 300));
        else if (pick < 8)
            c = c + int'($urandom_range(1, 300));
        else if (pick == 9)
            return 16'($urandom);
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        return 16'(c);
    endfunction

    // Mostly updates for a small pool of tracks moving around the line,
    // so tracks get stored, cross, go missing and fill the table; the rest
    // is noise over the whole input space.
    task automatic random_update();
        logic [15:0] id;
        logic [7:0]  act, inact;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_update(16'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom));
        end else begin
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 11) == 0)
                act = $urandom_range(0, 1) ? ACT_SKIP_LO : ACT_SKIP_HI;
            else
                act = 8'($urandom);
            inact = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            send_update(id, near_line(aim_x0), near_line(aim_y0), act, inact);
        end
    endtask

    task automatic run_setting(logic [11:0] x0, logic [11:0] y0, logic [11:0] x1,
                               logic [11:0] y1, logic on);
        set_line(x0, y0, x1, y1, on);
        repeat (RANDOM_PER_SETTING) random_update();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_X;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        calm          = 1'b0;
        updates_sent  = 0;
        settings_used = 0;
        aim_x0        = '0;
        aim_y0        = '0;
        for (int i = 0; i < 20; i++)
            id_pool[i] = 16'h0100 + 16'(i);
        id_pool[20] = 16'h0000;
        id_pool[21] = 16'hFFFF;
        id_pool[22] = 16'h01FF;
        id_pool[23] = 16'($urandom);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // counting still off after reset: side none, nothing stored
        send_update(16'd1, 16'd0, 16'd0, 8'd1, 8'd0);

        // vertical line at x = 100 px, reference 1600 in 12.4
        set_line(12'd100, 12'd0, 12'd120, 12'd700, 1'b1);
        send_update(16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0);      // new, side A
        send_update(16'h0000, 16'hFFFF, 16'hFFFF, 8'd1, 8'd0);      // A to B
        send_update(16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 8'd0);     // new, side B
        send_update(16'hFFFF, 16'h0000, 16'hFFFF, 8'd2, 8'd0);      // B to A, reverse
        send_update(16'd7, 16'd1599, 16'd0, 8'd3, 8'd0);            // just left of line
        send_update(16'd7, 16'd1600, 16'd0, 8'd3, 8'd0);            // onto the line
        send_update(16'd10, 16'd1601, 16'd0, 8'd5, 8'd0);           // just right, stored
        send_update(16'd10, 16'd0, 16'd0, ACT_SKIP_LO, 8'd0);       // skipped update
        send_update(16'd10, 16'd0, 16'd0, ACT_SKIP_HI, 8'hFF);      // skipped, even if missing
        // fill the remaining 15 slots, then one more finds the table full
        for (int i = 0; i < TRACK_SLOTS - 1; i++)
            send_update(16'h0100 + 16'(i), 16'd0, 16'd0, 8'd9, 8'd0);
        send_update(16'h01FF, 16'd0, 16'd0, 8'd9, 8'd0);
        send_update(16'd10, 16'd1601, 16'd0, 8'd9, 8'hFF);          // missing, slot freed
        send_update(16'h01FF, 16'd0, 16'd0, 8'd9, 8'd0);            // now fits
        repeat (RANDOM_PER_SETTING) random_update();

        run_setting(12'd10, 12'd2000, 12'd3000, 12'd2050, 1'b1);   // horizontal
        run_setting(12'd4095, 12'd0, 12'd4095, 12'd4095, 1'b1);    // vertical, right edge
        run_setting(12'd0, 12'd0, 12'd4095, 12'd0, 1'b1);          // horizontal, top edge
        run_setting(12'd4095, 12'd4095, 12'd0, 12'd4095, 1'b1);    // horizontal, bottom
        run_setting(12'd200, 12'd200, 12'd300, 12'd300, 1'b1);     // equal extents
        run_setting(12'd500, 12'd500, 12'd500, 12'd500, 1'b1);     // single point
        run_setting(12'd0, 12'd0, 12'd0, 12'd4095, 1'b1);          // vertical, left edge
        run_setting(12'd2048, 12'd100, 12'd2060, 12'd3000, 1'b0);  // counting off
        run_setting(12'd2048, 12'd100, 12'd2060, 12'd3000, 1'b1);  // back on, mid frame

        // let every outstanding result drain
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d track updates across %0d line settings; %0d results checked.",
                 updates_sent, settings_used, results_seen);
        $display("Results with a crossing: %0d, with the track table full: %0d.",
                 crossings_seen, full_seen);
        if (mismatches == 0 && awaiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/lctc_pkg.sv
sv/lctc_table.sv
sv/lctc_counters.sv
sv/line_crossing_track_counter.sv
sv/lctc_checker.sv
dv/line_crossing_track_counter_checker.sv
dv/line_crossing_track_counter_tb.sv
